>>> src/decayed_frequency_cache_policy_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decayed-frequency cache policy block.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DECAYED_FREQUENCY_CACHE_POLICY_TOP_DEFINES_SVH
`define DECAYED_FREQUENCY_CACHE_POLICY_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define DFCP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define DFCP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define DFCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dfcp_pkg.sv
// ----------------------------------------------------------------------------
// dfcp_pkg
// Shared constants and types of the decayed-frequency cache policy block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfcp_pkg;

  localparam int CAPACITY_DEF = 32;

  // Ages are unsigned Q4.12: 4096 stands for 1.0.
  localparam logic [15:0] AGE_ONE   = 16'h1000;
  localparam logic [15:0] AGE_MAX   = 16'hFFFF;
  // 0.9 as a fraction of 65536, truncated.
  localparam logic [15:0] DECAY_MUL = 16'd58982;

  typedef enum logic [1:0] {
    OUT_IGNORED  = 2'd0,
    OUT_HIT      = 2'd1,
    OUT_INSERTED = 2'd2,
    OUT_EVICTED  = 2'd3
  } outcome_t;

  // Write enables of the entry store.
  typedef struct packed {
    logic key_we;
    logic age_we;
  } wr_ctl_t;

endpackage

`default_nettype wire

>>> src/decayed_frequency_cache_policy_top.sv
// ----------------------------------------------------------------------------
// decayed_frequency_cache_policy_top
// Frequency-ranked cache policy with exponential ageing of entry ages.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_access_key       | sink
//   out     | out_valid, out_ready, out_outcome,      | source
//           | out_slot, out_evicted_key, out_occupancy|
//
// A null key goes from idle straight to the finish step, and a key that
// meets an empty store goes through the append step on its way there.
// Any other key costs one pass over the held entries: on a hit the pass
// is followed by the decide and finish steps, on a miss by decide, append
// and finish, and in_ready rises again with out_valid. The pass length is set by
// the single read port of the entry store, walked one entry a cycle through
// the one shared decay multiplier.
// Reset is synchronous and active low; it empties the store by clearing the
// fill count, so the memories need no clearing pass.
// A stalled result is held in the output register; the sequencer waits at
// its last step until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "decayed_frequency_cache_policy_top_defines.svh"

module decayed_frequency_cache_policy_top
  import dfcp_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_access_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_outcome,
  output logic [4:0]       out_slot,
  output logic [31:0]      out_evicted_key,
  output logic [5:0]       out_occupancy
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SWEEP  = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_APPEND = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic             pv_r, pv_nxt;
  logic             hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [31:0]      key_r, key_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [15:0]      hit_age_r, hit_age_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [15:0]      best_age_r, best_age_nxt;
  logic [31:0]      best_key_r, best_key_nxt;
  logic [31:0]      last_key_r, last_key_nxt;
  logic [15:0]      last_age_r, last_age_nxt;
  logic [IDX_W-1:0] app_idx_r, app_idx_nxt;

  outcome_t         res_outcome_r, res_outcome_nxt;
  logic [4:0]       res_slot_r, res_slot_nxt;
  logic [31:0]      res_evict_r, res_evict_nxt;
  logic [5:0]       res_occ_r, res_occ_nxt;

  outcome_t         out_outcome_r, out_outcome_nxt;
  logic [4:0]       out_slot_r, out_slot_nxt;
  logic [31:0]      out_evict_r, out_evict_nxt;
  logic [5:0]       out_occ_r, out_occ_nxt;

  // Store ports.
  wr_ctl_t          st_wr;
  logic [IDX_W-1:0] st_wr_addr;
  logic [31:0]      st_wr_key;
  logic [15:0]      st_wr_age;
  logic [IDX_W-1:0] st_rd_addr;
  logic [31:0]      st_rd_key;
  logic [15:0]      st_rd_age;

  dfcp_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_ctl  (st_wr),
    .wr_addr (st_wr_addr),
    .wr_key  (st_wr_key),
    .wr_age  (st_wr_age),
    .rd_addr (st_rd_addr),
    .rd_key  (st_rd_key),
    .rd_age  (st_rd_age)
  );

  // The shared unit: one 16 by 16 multiplier that scales an age by 0.9.
  logic [31:0] decay_prod;
  logic [15:0] decay_age;
  assign decay_prod = {16'd0, st_rd_age} * {16'd0, DECAY_MUL};
  assign decay_age  = decay_prod[31:16];

  // Hit increment, saturating just under 16.0.
  logic [16:0] hit_sum;
  logic [15:0] hit_sat;
  assign hit_sum = {1'b0, hit_age_r} + {1'b0, AGE_ONE};
  assign hit_sat = hit_sum[16] ? AGE_MAX : hit_sum[15:0];

  logic issue_go;
  logic out_free;
  logic last_elem;
  logic key_match;
  assign issue_go  = (state_r == ST_SWEEP) && (issue_idx_r < count_r);
  assign out_free  = !out_valid_r || out_ready;
  assign last_elem = (CNT_W'(pidx_r) == (count_r - CNT_ONE));
  assign key_match = (st_rd_key == key_r);

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_slot        = out_slot_r;
  assign out_evicted_key = out_evict_r;
  assign out_occupancy   = out_occ_r;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    issue_idx_nxt   = issue_idx_r;
    pv_nxt          = 1'b0;
    hit_nxt         = hit_r;
    key_nxt         = key_r;
    pidx_nxt        = pidx_r;
    hit_idx_nxt     = hit_idx_r;
    hit_age_nxt     = hit_age_r;
    best_idx_nxt    = best_idx_r;
    best_age_nxt    = best_age_r;
    best_key_nxt    = best_key_r;
    last_key_nxt    = last_key_r;
    last_age_nxt    = last_age_r;
    app_idx_nxt     = app_idx_r;
    res_outcome_nxt = res_outcome_r;
    res_slot_nxt    = res_slot_r;
    res_evict_nxt   = res_evict_r;
    res_occ_nxt     = res_occ_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_outcome_nxt = out_outcome_r;
    out_slot_nxt    = out_slot_r;
    out_evict_nxt   = out_evict_r;
    out_occ_nxt     = out_occ_r;

    st_wr        = '0;
    st_wr_addr   = pidx_r;
    st_wr_key    = key_r;
    st_wr_age    = decay_age;
    st_rd_addr   = issue_go ? issue_idx_r[IDX_W-1:0] : '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt       = in_access_key;
          issue_idx_nxt = '0;
          hit_nxt       = 1'b0;
          if (in_access_key == 32'd0) begin
            // Null key: nothing changes, not even the ages.
            res_outcome_nxt = OUT_IGNORED;
            res_slot_nxt    = 5'd0;
            res_evict_nxt   = 32'd0;
            res_occ_nxt     = 6'(count_r);
            state_nxt       = ST_FINISH;
          end else if (count_r == '0) begin
            app_idx_nxt     = '0;
            res_outcome_nxt = OUT_INSERTED;
            res_evict_nxt   = 32'd0;
            state_nxt       = ST_APPEND;
          end else begin
            state_nxt = ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        // Read one entry a cycle; its data comes back on the next cycle.
        if (issue_go) begin
          pv_nxt        = 1'b1;
          pidx_nxt      = issue_idx_r[IDX_W-1:0];
          issue_idx_nxt = issue_idx_r + CNT_ONE;
        end
        if (pv_r) begin
          // Decayed age goes back to the entry it came from.
          st_wr.age_we = 1'b1;
          st_wr_addr   = pidx_r;
          st_wr_age    = decay_age;
          if (key_match && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pidx_r;
            hit_age_nxt = decay_age;
          end
          // Strict compare keeps the lowest index on a tie.
          if ((pidx_r == '0) || (decay_age < best_age_r)) begin
            best_idx_nxt = pidx_r;
            best_age_nxt = decay_age;
            best_key_nxt = st_rd_key;
          end
          if (last_elem) begin
            last_key_nxt = st_rd_key;
            last_age_nxt = decay_age;
            state_nxt    = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (hit_r) begin
          st_wr.age_we    = 1'b1;
          st_wr_addr      = hit_idx_r;
          st_wr_age       = hit_sat;
          res_outcome_nxt = OUT_HIT;
          res_slot_nxt    = 5'(hit_idx_r);
          res_evict_nxt   = 32'd0;
          res_occ_nxt     = 6'(count_r);
          state_nxt       = ST_FINISH;
        end else if (count_r == CNT_FULL) begin
          // Evict the smallest age; the last entry fills its slot.
          st_wr.key_we    = 1'b1;
          st_wr.age_we    = 1'b1;
          st_wr_addr      = best_idx_r;
          st_wr_key       = last_key_r;
          st_wr_age       = last_age_r;
          app_idx_nxt     = IDX_W'(count_r - CNT_ONE);
          res_outcome_nxt = OUT_EVICTED;
          res_evict_nxt   = best_key_r;
          state_nxt       = ST_APPEND;
        end else begin
          app_idx_nxt     = IDX_W'(count_r);
          res_outcome_nxt = OUT_INSERTED;
          res_evict_nxt   = 32'd0;
          state_nxt       = ST_APPEND;
        end
      end

      ST_APPEND: begin
        st_wr.key_we = 1'b1;
        st_wr.age_we = 1'b1;
        st_wr_addr   = app_idx_r;
        st_wr_key    = key_r;
        st_wr_age    = AGE_ONE;
        count_nxt    = CNT_W'(app_idx_r) + CNT_ONE;
        res_slot_nxt = 5'(app_idx_r);
        res_occ_nxt  = 6'(CNT_W'(app_idx_r) + CNT_ONE);
        state_nxt    = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = res_outcome_r;
          out_slot_nxt    = res_slot_r;
          out_evict_nxt   = res_evict_r;
          out_occ_nxt     = res_occ_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issue_idx_r <= '0;
      pv_r        <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_idx_r <= issue_idx_nxt;
      pv_r        <= pv_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    pidx_r        <= pidx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_age_r     <= hit_age_nxt;
    best_idx_r    <= best_idx_nxt;
    best_age_r    <= best_age_nxt;
    best_key_r    <= best_key_nxt;
    last_key_r    <= last_key_nxt;
    last_age_r    <= last_age_nxt;
    app_idx_r     <= app_idx_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_slot_r    <= res_slot_nxt;
    res_evict_r   <= res_evict_nxt;
    res_occ_r     <= res_occ_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
    out_evict_r   <= out_evict_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  // The fill count never passes the capacity.
  `DFCP_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_FULL, "fill count above capacity")
  // Every entry handled in the pass lies below the fill count.
  `DFCP_ASSERT_SAME(a_pass_in_range, pv_r, CNT_W'(pidx_r) < count_r, "pass beyond fill count")
  // A taken beat always starts the sequencer.
  `DFCP_ASSERT_NEXT(a_beat_starts, in_valid && in_ready, state_r != ST_IDLE, "beat not started")
  // Each finished access with a free output register is loaded into that register.
  `DFCP_ASSERT_NEXT(a_result_loaded, state_r == ST_FINISH && out_free, out_valid_r, "result lost")

endmodule

`default_nettype wire

>>> src/dfcp_store.sv
// ----------------------------------------------------------------------------
// dfcp_store
// Entry store: key and age memories with one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfcp_store
  import dfcp_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  wire logic             clk,
  input  wire wr_ctl_t          wr_ctl,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [31:0]      wr_key,
  input  wire logic [15:0]      wr_age,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [31:0]      rd_key,
  output logic      [15:0]      rd_age
);

  logic [31:0] key_mem [CAPACITY];
  logic [15:0] age_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.age_we) begin
      age_mem[wr_addr] <= wr_age;
    end
    rd_age <= age_mem[rd_addr];
  end

endmodule

`default_nettype wire
